// ===== rtl/gdfs_pkg.sv =====
// Package for the adjacency-matrix depth-first search block.
// Holds field widths, default sizes, command and status codes, and the FSM state type.
// No dependencies.
package gdfs_pkg;

    // Field widths fixed by the channel format.
    localparam int CMD_W    = 2;
    localparam int NODE_W   = 6;
    localparam int STATUS_W = 3;
    localparam int CFG_W    = 7;

    // Default sizes and register reset value.
    localparam int NODES_DEF       = 64;
    localparam int STACK_DEPTH_DEF = 128;
    localparam int NODE_COUNT_RST  = 64;

    // Input commands; the fourth code is unused and ignored.
    typedef enum logic [CMD_W-1:0] {
        CMD_ADD_EDGE = 2'd0,
        CMD_SEARCH   = 2'd1,
        CMD_CLEAR    = 2'd2
    } cmd_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STAT_VISIT     = 3'd0,
        STAT_EDGE_OK   = 3'd1,
        STAT_EDGE_BAD  = 3'd2,
        STAT_START_BAD = 3'd3,
        STAT_CLEARED   = 3'd4
    } status_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_EDGE,
        S_EMIT,
        S_POP,
        S_ROW,
        S_MASK,
        S_PUSH
    } state_t;

endpackage

// ===== rtl/gdfs_req_if.sv =====
// Request channel interface: command beats into the search block.
// Depends on gdfs_pkg for field widths.
interface gdfs_req_if;
    logic                        valid;
    logic                        ready;
    logic [gdfs_pkg::CMD_W-1:0]  cmd;
    logic [gdfs_pkg::NODE_W-1:0] from_node;
    logic [gdfs_pkg::NODE_W-1:0] to_node;

    modport source (output valid, output cmd, output from_node, output to_node, input ready);
    modport sink   (input valid, input cmd, input from_node, input to_node, output ready);
endinterface

// ===== rtl/gdfs_rsp_if.sv =====
// Result channel interface: result beats out of the search block.
// Depends on gdfs_pkg for field widths.
interface gdfs_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [gdfs_pkg::STATUS_W-1:0] status;
    logic [gdfs_pkg::NODE_W-1:0]   node;
    logic                          overflow;
    logic                          last;

    modport source (output valid, output status, output node, output overflow, output last,
                    input ready);
    modport sink   (input valid, input status, input node, input overflow, input last,
                    output ready);
endinterface

// ===== rtl/gdfs_cfg_if.sv =====
// Configuration write channel interface carrying the node count register.
// Depends on gdfs_pkg for the register width.
interface gdfs_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [gdfs_pkg::CFG_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/graph_dfs_adjacency_matrix_top.sv =====
// Depth-first search over a bit adjacency matrix held in a row memory, with a node stack memory.
// Depends on gdfs_pkg and the gdfs_req_if, gdfs_rsp_if and gdfs_cfg_if interfaces.
// Add edge reads the row, then writes it back in S_EDGE; clear and rejected commands go through S_EMIT.
// Search: the start node is pushed on accept, then each popped node passes S_POP, S_ROW, S_MASK and S_PUSH,
// and a final S_POP emits the last beat. Result stalls hold the sequencer in S_EDGE, S_EMIT, S_ROW or S_POP.
// Reset clears all control state; rows read as empty through per-row valid bits, no sweep.
module graph_dfs_adjacency_matrix_top #(
    parameter int NODES       = gdfs_pkg::NODES_DEF,
    parameter int STACK_DEPTH = gdfs_pkg::STACK_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    gdfs_req_if.sink       req,
    gdfs_rsp_if.source     rsp,
    gdfs_cfg_if.sink       cfg
);
    import gdfs_pkg::*;

    localparam int IDX_W  = $clog2(NODES);
    localparam int SADR_W = $clog2(STACK_DEPTH);
    localparam int FILL_W = $clog2(STACK_DEPTH + 1);

    // Memories.
    logic [NODES-1:0]  adj_mem [NODES];
    logic [NODE_W-1:0] stk_mem [STACK_DEPTH];

    // Control registers.
    state_t             state_reg, state_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [NODES-1:0]   visited_reg, visited_next;
    logic               ovf_reg, ovf_next;
    logic [NODES-1:0]   row_valid_reg, row_valid_next;
    logic               out_valid_reg, out_valid_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [CFG_W-1:0]   node_count_reg;

    // Payload registers.
    logic [NODES-1:0]   mask_reg, mask_next;
    logic [NODE_W-1:0]  pend_node_reg, pend_node_next;
    logic               pend_ovf_reg, pend_ovf_next;
    logic [NODE_W-1:0]  from_reg, from_next;
    logic [NODE_W-1:0]  to_reg, to_next;
    status_t            res_status_reg, res_status_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [NODE_W-1:0]  out_node_reg, out_node_next;
    logic               out_ovf_reg, out_ovf_next;
    logic               out_last_reg, out_last_next;

    // Memory ports.
    logic               adj_re, adj_we;
    logic [IDX_W-1:0]   adj_raddr, adj_waddr;
    logic [NODES-1:0]   adj_wdata, adj_rd_reg;
    logic               adj_vld_rd_reg;
    logic               stk_re, stk_we;
    logic [SADR_W-1:0]  stk_raddr, stk_waddr;
    logic [NODE_W-1:0]  stk_wdata, stk_rd_reg;

    // Derived values.
    logic [CFG_W-1:0]   ncnt;
    logic [NODES-1:0]   act_mask;
    logic [NODES-1:0]   eff_row;
    logic [IDX_W-1:0]   hi_idx;
    logic [FILL_W-1:0]  fill_dec;
    logic               from_ok, to_ok, out_free;

    // Active node count saturates to the matrix size.
    assign ncnt     = (node_count_reg > CFG_W'(NODES)) ? CFG_W'(NODES) : node_count_reg;
    assign from_ok  = CFG_W'(req.from_node) < ncnt;
    assign to_ok    = CFG_W'(req.to_node) < ncnt;
    assign eff_row  = adj_vld_rd_reg ? adj_rd_reg : '0;
    assign fill_dec = fill_reg - FILL_W'(1);
    assign out_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        for (int i = 0; i < NODES; i++)
        begin
            act_mask[i] = CFG_W'(i) < ncnt;
        end
    end

    // Highest pending neighbor; pushing high first makes neighbors pop in ascending order.
    always_comb
    begin
        hi_idx = '0;
        for (int i = 0; i < NODES; i++)
        begin
            if (mask_reg[i])
            begin
                hi_idx = IDX_W'(i);
            end
        end
    end

    // Ports.
    assign req.ready    = (state_reg == S_IDLE);
    assign cfg.ready    = 1'b1;
    assign rsp.valid    = out_valid_reg;
    assign rsp.status   = out_status_reg;
    assign rsp.node     = out_node_reg;
    assign rsp.overflow = out_ovf_reg;
    assign rsp.last     = out_last_reg;

    // Sequencer: next state, memory controls and result beats.
    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        visited_next    = visited_reg;
        ovf_next        = ovf_reg;
        row_valid_next  = row_valid_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        pend_valid_next = pend_valid_reg;
        mask_next       = mask_reg;
        pend_node_next  = pend_node_reg;
        pend_ovf_next   = pend_ovf_reg;
        from_next       = from_reg;
        to_next         = to_reg;
        res_status_next = res_status_reg;
        out_status_next = out_status_reg;
        out_node_next   = out_node_reg;
        out_ovf_next    = out_ovf_reg;
        out_last_next   = out_last_reg;
        adj_re          = 1'b0;
        adj_we          = 1'b0;
        adj_raddr       = from_reg[IDX_W-1:0];
        adj_waddr       = from_reg[IDX_W-1:0];
        adj_wdata       = eff_row | ({{(NODES-1){1'b0}}, 1'b1} << to_reg[IDX_W-1:0]);
        stk_re          = 1'b0;
        stk_we          = 1'b0;
        stk_raddr       = fill_dec[SADR_W-1:0];
        stk_waddr       = fill_reg[SADR_W-1:0];
        stk_wdata       = NODE_W'(hi_idx);

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    from_next = req.from_node;
                    to_next   = req.to_node;
                    unique case (req.cmd)
                        CMD_ADD_EDGE:
                        begin
                            if (from_ok && to_ok)
                            begin
                                adj_re     = 1'b1;
                                adj_raddr  = req.from_node[IDX_W-1:0];
                                state_next = S_EDGE;
                            end
                            else
                            begin
                                res_status_next = STAT_EDGE_BAD;
                                state_next      = S_EMIT;
                            end
                        end
                        CMD_SEARCH:
                        begin
                            if (from_ok)
                            begin
                                visited_next    = '0;
                                ovf_next        = 1'b0;
                                pend_valid_next = 1'b0;
                                stk_we          = 1'b1;
                                stk_waddr       = '0;
                                stk_wdata       = req.from_node;
                                fill_next       = FILL_W'(1);
                                state_next      = S_POP;
                            end
                            else
                            begin
                                res_status_next = STAT_START_BAD;
                                state_next      = S_EMIT;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            row_valid_next  = '0;
                            res_status_next = STAT_CLEARED;
                            state_next      = S_EMIT;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // Write the updated row back and report the added edge.
            S_EDGE:
            begin
                if (out_free)
                begin
                    adj_we                             = 1'b1;
                    row_valid_next[from_reg[IDX_W-1:0]] = 1'b1;
                    out_valid_next                     = 1'b1;
                    out_status_next                    = STAT_EDGE_OK;
                    out_node_next                      = '0;
                    out_ovf_next                       = ovf_reg;
                    out_last_next                      = 1'b1;
                    state_next                         = S_IDLE;
                end
            end

            // Single-beat results.
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_node_next   = '0;
                    out_ovf_next    = ovf_reg;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            // Pop the top of stack, or finish with the held visit beat marked last.
            S_POP:
            begin
                if (fill_reg == '0)
                begin
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = STAT_VISIT;
                        out_node_next   = pend_node_reg;
                        out_ovf_next    = pend_ovf_reg;
                        out_last_next   = 1'b1;
                        pend_valid_next = 1'b0;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    stk_re     = 1'b1;
                    fill_next  = fill_dec;
                    state_next = S_ROW;
                end
            end

            // Mark a new node and release the previous visit beat; fetch the popped node's row in either case.
            S_ROW:
            begin
                adj_raddr = stk_rd_reg[IDX_W-1:0];
                if (visited_reg[stk_rd_reg[IDX_W-1:0]])
                begin
                    adj_re     = 1'b1;
                    state_next = S_MASK;
                end
                else if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = STAT_VISIT;
                        out_node_next   = pend_node_reg;
                        out_ovf_next    = pend_ovf_reg;
                        out_last_next   = 1'b0;
                    end
                    pend_valid_next                       = 1'b1;
                    pend_node_next                        = stk_rd_reg;
                    pend_ovf_next                         = ovf_reg;
                    visited_next[stk_rd_reg[IDX_W-1:0]]   = 1'b1;
                    adj_re                                = 1'b1;
                    state_next                            = S_MASK;
                end
            end

            // Neighbors still to push: in the row, unvisited, below the active count.
            S_MASK:
            begin
                mask_next  = eff_row & ~visited_reg & act_mask;
                state_next = S_PUSH;
            end

            // Push one neighbor per cycle, highest index first; a full stack drops it.
            S_PUSH:
            begin
                if (mask_reg == '0)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    mask_next[hi_idx] = 1'b0;
                    if (fill_reg == FILL_W'(STACK_DEPTH))
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        stk_we    = 1'b1;
                        fill_next = fill_reg + FILL_W'(1);
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fill_reg       <= '0;
            visited_reg    <= '0;
            ovf_reg        <= 1'b0;
            row_valid_reg  <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            node_count_reg <= CFG_W'(NODE_COUNT_RST);
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            visited_reg    <= visited_next;
            ovf_reg        <= ovf_next;
            row_valid_reg  <= row_valid_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
            if (cfg.valid)
            begin
                node_count_reg <= cfg.data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        mask_reg       <= mask_next;
        pend_node_reg  <= pend_node_next;
        pend_ovf_reg   <= pend_ovf_next;
        from_reg       <= from_next;
        to_reg         <= to_next;
        res_status_reg <= res_status_next;
        out_status_reg <= out_status_next;
        out_node_reg   <= out_node_next;
        out_ovf_reg    <= out_ovf_next;
        out_last_reg   <= out_last_next;
    end

    // Adjacency row memory with registered read and the row valid bit alongside.
    always_ff @(posedge clk)
    begin
        if (adj_we)
        begin
            adj_mem[adj_waddr] <= adj_wdata;
        end
        if (adj_re)
        begin
            adj_rd_reg     <= adj_mem[adj_raddr];
            adj_vld_rd_reg <= row_valid_reg[adj_raddr];
        end
    end

    // Node stack memory with registered read.
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        if (stk_re)
        begin
            stk_rd_reg <= stk_mem[stk_raddr];
        end
    end

    // The stack fill never passes the stack depth.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(STACK_DEPTH))
        else $error("stack fill beyond depth");

    // A search always drains the stack before the block goes idle.
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> fill_reg == '0)
        else $error("idle with stack entries left");

    // Overflow is only raised by a dropped push.
    a_ovf_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovf_reg) |-> $past(state_reg) == S_PUSH)
        else $error("overflow set outside a push");

    // Neighbor expansion only follows a recorded visit.
    a_pend_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MASK || state_reg == S_PUSH) |-> pend_valid_reg)
        else $error("expanding without a pending visit");

    // Every result other than a visit is the only beat of its command.
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != STAT_VISIT) |-> out_last_reg)
        else $error("non-visit result without last");

endmodule

// ===== bench/graph_dfs_adjacency_matrix_top_tb.sv =====
// Self-checking testbench for the adjacency-matrix depth-first search block.
// Drives command beats and node count writes, predicts every result beat, and checks them.
// Depends on gdfs_pkg, the three channel interfaces and the top level.
`timescale 1ns / 100ps

module graph_dfs_adjacency_matrix_top_tb;
    import gdfs_pkg::*;

    localparam int          NODES         = NODES_DEF;
    localparam int          STACK_DEPTH   = STACK_DEPTH_DEF;
    localparam int          SETTLE_CYCLES = 12;
    localparam int          IDLE_PCT      = 11;
    localparam int          REPORT_LIMIT  = 10;
    localparam logic [1:0]  CMD_UNUSED    = 2'd3;

    // One result beat as the block should present it.
    typedef struct packed {
        status_t             status;
        logic [NODE_W-1:0]   node;
        logic                overflow;
        logic                last;
    } result_t;

    logic clk;
    logic rst_n;

    gdfs_req_if req_ch ();
    gdfs_rsp_if rsp_ch ();
    gdfs_cfg_if cfg_ch ();

    graph_dfs_adjacency_matrix_top #(
        .NODES       (NODES),
        .STACK_DEPTH (STACK_DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Shadow of the block's graph, flags and node count register.
    logic [NODES-1:0]  adj_rows [NODES];
    logic              overflow_flag;
    logic [CFG_W-1:0]  node_count_reg;

    result_t due_results [$];
    int      mismatches;
    bit      req_idle_on;
    bit      rsp_idle_on;

    always #6 clk = ~clk;

    // Result ready with random stalls, changed on the falling edge.
    always @(negedge clk)
    begin
        rsp_ch.ready <= rsp_idle_on ? ($urandom_range(0, 99) >= IDLE_PCT) : 1'b1;
    end

    task automatic report_mismatch(input string what, input result_t want, input result_t got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t mismatch (%s): expected status=%0d node=%0d ovf=%0b last=%0b,",
                     $realtime, what, want.status, want.node, want.overflow, want.last,
                     " got status=%0d node=%0d ovf=%0b last=%0b",
                     got.status, got.node, got.overflow, got.last);
    endtask

    // Compare each accepted result beat with the oldest expectation.
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.status   = status_t'(rsp_ch.status);
            got.node     = rsp_ch.node;
            got.overflow = rsp_ch.overflow;
            got.last     = rsp_ch.last;
            if (due_results.size() == 0)
            begin
                report_mismatch("no result expected", '0, got);
            end
            else
            begin
                want = due_results.pop_front();
                if (got.status !== want.status || got.node !== want.node ||
                    got.overflow !== want.overflow || got.last !== want.last)
                    report_mismatch("field", want, got);
            end
        end
    end

    task automatic queue_result(input status_t st, input logic [NODE_W-1:0] nd, input logic lst);
        result_t r;
        r.status   = st;
        r.node     = nd;
        r.overflow = overflow_flag;
        r.last     = lst;
        due_results.push_back(r);
    endtask

    // Work out the result beats that one accepted command causes.
    task automatic derive_results(input logic [1:0] op, input logic [NODE_W-1:0] src,
                                  input logic [NODE_W-1:0] dst);
        int                n;
        int                fill;
        int                emitted;
        int                idx;
        logic [NODE_W-1:0] v;
        logic [NODES-1:0]  row;
        logic [NODES-1:0]  seen;
        logic [NODE_W-1:0] stk [STACK_DEPTH];
        n = (node_count_reg > NODES) ? NODES : int'(node_count_reg);
        case (op)
            CMD_ADD_EDGE:
            begin
                if (src >= n || dst >= n)
                    queue_result(STAT_EDGE_BAD, '0, 1'b1);
                else
                begin
                    adj_rows[src][dst] = 1'b1;
                    queue_result(STAT_EDGE_OK, '0, 1'b1);
                end
            end
            CMD_CLEAR:
            begin
                for (idx = 0; idx < NODES; idx++)
                    adj_rows[idx] = '0;
                queue_result(STAT_CLEARED, '0, 1'b1);
            end
            CMD_SEARCH:
            begin
                if (src >= n)
                    queue_result(STAT_START_BAD, '0, 1'b1);
                else
                begin
                    seen          = '0;
                    overflow_flag = 1'b0;
                    emitted       = 0;
                    stk[0]        = src;
                    fill          = 1;
                    while (fill > 0)
                    begin
                        fill--;
                        v = stk[fill];
                        if (!seen[v])
                        begin
                            seen[v] = 1'b1;
                            if (emitted < NODES)
                            begin
                                queue_result(STAT_VISIT, v, 1'b0);
                                emitted++;
                            end
                        end
                        // Push unvisited neighbors from the top index down.
                        row = adj_rows[v];
                        for (idx = n - 1; idx >= 0; idx--)
                        begin
                            if (row[idx] && !seen[idx])
                            begin
                                if (fill >= STACK_DEPTH)
                                    overflow_flag = 1'b1;
                                else
                                begin
                                    stk[fill] = idx[NODE_W-1:0];
                                    fill++;
                                end
                            end
                        end
                    end
                    if (emitted > 0)
                        due_results[$].last = 1'b1;
                end
            end
            default: ;
        endcase
    endtask

    // Send one command beat; valid stays high until the next call or a drain lowers it.
    task automatic send_command(input logic [1:0] op, input logic [NODE_W-1:0] src,
                                input logic [NODE_W-1:0] dst);
        @(negedge clk);
        while (req_idle_on && $urandom_range(0, 99) < IDLE_PCT)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.cmd       <= op;
        req_ch.from_node <= src;
        req_ch.to_node   <= dst;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        derive_results(op, src, dst);
    endtask

    // Lower valid, wait for every expected beat, then let the block settle.
    task automatic wait_idle();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (due_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_node_count(input logic [CFG_W-1:0] value);
        wait_idle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        node_count_reg = value;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Reset count of 64: edges and a walk on the outermost nodes.
    task automatic test_default_count();
        send_command(CMD_ADD_EDGE, 6'd63, 6'd0);
        send_command(CMD_ADD_EDGE, 6'd0, 6'd63);
        send_command(CMD_SEARCH, 6'd63, 6'd63);
    endtask

    // Edges with an end at or past the node count are rejected.
    task automatic test_edge_bounds();
        write_node_count(7'd12);
        send_command(CMD_ADD_EDGE, 6'd11, 6'd11);
        send_command(CMD_ADD_EDGE, 6'd12, 6'd0);
        send_command(CMD_ADD_EDGE, 6'd0, 6'd12);
        send_command(CMD_ADD_EDGE, 6'd5, 6'd63);
        send_command(CMD_ADD_EDGE, 6'd11, 6'd3);
        send_command(CMD_ADD_EDGE, 6'd3, 6'd7);
        send_command(CMD_ADD_EDGE, 6'd11, 6'd7);
        send_command(CMD_SEARCH, 6'd11, 6'd0);
    endtask

    // Invalid start nodes give one beat; the unused command gives none.
    task automatic test_start_and_unused();
        send_command(CMD_SEARCH, 6'd12, 6'd0);
        send_command(CMD_UNUSED, 6'd63, 6'd63);
        send_command(CMD_SEARCH, 6'd40, 6'd21);
        send_command(CMD_SEARCH, 6'd3, 6'd0);
    endtask

    // Clearing drops every edge, so a walk sees only its start.
    task automatic test_clear_graph();
        send_command(CMD_CLEAR, 6'd0, 6'd0);
        send_command(CMD_SEARCH, 6'd11, 6'd0);
    endtask

    // Zero count rejects edges and searches; one node; oversized count acts as full size.
    task automatic test_count_extremes();
        write_node_count(7'd0);
        send_command(CMD_ADD_EDGE, 6'd0, 6'd0);
        send_command(CMD_SEARCH, 6'd0, 6'd0);
        send_command(CMD_CLEAR, 6'd0, 6'd0);
        write_node_count(7'd1);
        send_command(CMD_ADD_EDGE, 6'd0, 6'd0);
        send_command(CMD_ADD_EDGE, 6'd0, 6'd1);
        send_command(CMD_SEARCH, 6'd0, 6'd0);
        write_node_count(7'd127);
        send_command(CMD_ADD_EDGE, 6'd63, 6'd62);
        send_command(CMD_ADD_EDGE, 6'd62, 6'd63);
        send_command(CMD_SEARCH, 6'd62, 6'd0);
    endtask

    // Dense fan-out from nodes 0, 1 and 2 fills the stack and drops pushes.
    // The edge load runs as one long stretch with no idling on either side.
    task automatic test_stack_overflow();
        int b;
        write_node_count(7'd64);
        send_command(CMD_CLEAR, 6'd0, 6'd0);
        req_idle_on = 1'b0;
        rsp_idle_on = 1'b0;
        for (b = 1; b < NODES; b++)
            send_command(CMD_ADD_EDGE, 6'd0, b[NODE_W-1:0]);
        for (b = 2; b < NODES; b++)
            send_command(CMD_ADD_EDGE, 6'd1, b[NODE_W-1:0]);
        for (b = NODES - 6; b < NODES; b++)
            send_command(CMD_ADD_EDGE, 6'd2, b[NODE_W-1:0]);
        req_idle_on = 1'b1;
        rsp_idle_on = 1'b1;
        send_command(CMD_SEARCH, 6'd0, 6'd0);
        // The flag persists on edge and clear beats until a valid search starts.
        send_command(CMD_ADD_EDGE, 6'd3, 6'd4);
        send_command(CMD_SEARCH, 6'd5, 6'd0);
        send_command(CMD_CLEAR, 6'd0, 6'd0);
    endtask

    // Random graphs under a small and an oversized node count.
    task automatic test_random_graphs();
        int                phase;
        int                k;
        int                roll;
        int                n;
        logic [CFG_W-1:0]  count;
        logic [NODE_W-1:0] src;
        logic [NODE_W-1:0] dst;
        for (phase = 0; phase < 2; phase++)
        begin
            case (phase)
                0:       count = 7'($urandom_range(2, 16));
                default: count = 7'($urandom_range(65, 127));
            endcase
            write_node_count(count);
            n = (count > NODES) ? NODES : int'(count);
            send_command(CMD_CLEAR, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
            k = 0;
            while (k < 6)
            begin
                roll = $urandom_range(0, 99);
                if ($urandom_range(0, 9) == 0)
                begin
                    src = 6'($urandom_range(0, 63));
                    dst = 6'($urandom_range(0, 63));
                end
                else
                begin
                    src = 6'($urandom_range(0, n - 1));
                    dst = 6'($urandom_range(0, n - 1));
                end
                if (roll < 58)
                begin
                    send_command(CMD_ADD_EDGE, src, dst);
                    k++;
                end
                else if (roll < 84)
                begin
                    send_command(CMD_SEARCH, src, dst);
                    k++;
                end
                else if (roll < 90)
                begin
                    send_command(CMD_CLEAR, src, dst);
                    k++;
                end
                else
                    send_command(CMD_UNUSED, src, dst);
            end
        end
    endtask

    initial
    begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.cmd       = '0;
        req_ch.from_node = '0;
        req_ch.to_node   = '0;
        rsp_ch.ready     = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.data      = '0;
        for (int i = 0; i < NODES; i++)
            adj_rows[i] = '0;
        overflow_flag  = 1'b0;
        node_count_reg = 7'(NODE_COUNT_RST);
        mismatches     = 0;
        req_idle_on    = 1'b1;
        rsp_idle_on    = 1'b1;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_default_count();
        test_edge_bounds();
        test_start_and_unused();
        test_clear_graph();
        test_count_extremes();
        test_stack_overflow();
        test_random_graphs();

        wait_idle();
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Hard limit on the run in case the block hangs or drops a beat.
    initial
    begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
